[rtl/core/fqpc_pkg.sv]
`default_nettype none
package fqpc_pkg;

  // Default ring depth. The top level carries it as a parameter.
  localparam int DEPTH_DEFAULT = 8;

  // Request codes.
  localparam logic [1:0] FUNC_ADD     = 2'd0;
  localparam logic [1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH   = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic               frame_present;
    logic signed [63:0] frame_pts;
    logic signed [31:0] target_pts;
    logic [7:0]         display_offset;
  } req_t;

  typedef struct packed {
    logic               caught_up;
    logic [3:0]         frames_buffered;
    logic [31:0]        frames_played;
    logic signed [63:0] next_pts;
    logic               ready_for_frame;
    logic [2:0]         show_slot;
    logic               overflow;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_NEXT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

[rtl/core/fqpc_pts_ram.sv]
`default_nettype none
module fqpc_pts_ram #(
  parameter int DEPTH = fqpc_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [63:0]       wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic [63:0]            rd_data
);
  import fqpc_pkg::*;

  logic [63:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [63:0]    rd_word;
  logic           rd_valid;

  // A slot that was never written since reset or flush reads as zero.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word  <= mem[rd_addr];
    rd_valid <= valid[rd_addr];
  end

  assign rd_data = rd_valid ? rd_word : 64'd0;

endmodule
`default_nettype wire

[rtl/core/frame_queue_pts_catchup.sv]
// Frame queue with timestamp catch-up. A word is accepted on a rising edge where start is
// high and busy is low; busy stays high until the one result word has been shown, so the
// block works on one request at a time. Every request returns exactly one result word,
// which sits on the result port for a single cycle marked by done; the receiver cannot
// stall it and must take it in that cycle. An add, a flush, a single-frame step or an
// advance on an empty ring passes through the execute, next and done states. A catch-up
// advance with a positive target passes from execute into a scan state that walks the ring
// one slot per cycle through the single read port of the timestamp memory, dropping head
// frames older than the target, and goes to done when a frame is kept or the ring runs dry.
// Reset and flush clear the timestamp store at once through per-slot valid bits; there is
// no clearing pass.
`default_nettype none
module frame_queue_pts_catchup #(
  parameter int DEPTH = fqpc_pkg::DEPTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire fqpc_pkg::req_t req,
  output logic                done,
  output fqpc_pkg::rsp_t      result
);
  import fqpc_pkg::*;

  // Slot pointer and fill counter widths.
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // Width of head pointer plus clipped display offset (both below 2 * 256).
  localparam int SW = 10;

  state_t          state, state_next;
  req_t            req_q;
  logic [PW-1:0]   rptr, rptr_next;
  logic [PW-1:0]   wptr, wptr_next;
  logic [CW-1:0]   count, count_next;
  logic [31:0]     played, played_next;
  logic            caught, caught_next;
  logic            ovf, ovf_next;

  logic            wr_en;
  logic            clear;
  logic [PW-1:0]   rd_addr;
  logic [63:0]     rd_data;

  logic [PW-1:0]   rptr_inc;
  logic [PW-1:0]   wptr_inc;
  logic            full;
  logic            positive;
  logic            head_less;
  logic signed [63:0] target_ext;

  logic [8:0]      off_ext;
  logic [8:0]      cnt_ext;
  logic [8:0]      off_clip;
  logic [SW-1:0]   slot_sum;
  logic [SW-1:0]   slot_mod;

  fqpc_pts_ram #(
    .DEPTH (DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .wr_en   (wr_en),
    .wr_addr (wptr),
    .wr_data (req_q.frame_pts),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Pointer increments wrap at DEPTH, which need not be a power of two.
  assign rptr_inc = (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
  assign wptr_inc = (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
  assign full     = (count == CW'(DEPTH));

  // The target is signed 32 bits; positive means strictly above zero.
  assign positive   = !req_q.target_pts[31] && (req_q.target_pts != 32'sd0);
  assign target_ext = {{32{req_q.target_pts[31]}}, req_q.target_pts};

  // The single compare unit: head timestamp from the memory against the target.
  assign head_less  = $signed(rd_data) < target_ext;

  // The execute cycle fetches the head slot; every other cycle fetches the slot after it.
  // During a scan that second fetch is the new head if the head is dropped, or the
  // lookahead timestamp if it is kept.
  assign rd_addr = (state == ST_EXEC) ? rptr : rptr_inc;

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rptr   <= '0;
      wptr   <= '0;
      count  <= '0;
      played <= '0;
      caught <= 1'b0;
      ovf    <= 1'b0;
    end else begin
      state  <= state_next;
      rptr   <= rptr_next;
      wptr   <= wptr_next;
      count  <= count_next;
      played <= played_next;
      caught <= caught_next;
      ovf    <= ovf_next;
    end
  end

  always_comb begin
    state_next  = state;
    rptr_next   = rptr;
    wptr_next   = wptr;
    count_next  = count;
    played_next = played;
    caught_next = caught;
    ovf_next    = ovf;
    wr_en       = 1'b0;
    clear       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        caught_next = 1'b0;
        ovf_next    = 1'b0;
        state_next  = ST_NEXT;
        case (req_q.func)
          FUNC_ADD: begin
            if (full) begin
              ovf_next = 1'b1;
            end else begin
              // A frame without a timestamp still takes a slot.
              wr_en      = req_q.frame_present;
              wptr_next  = wptr_inc;
              count_next = count + CW'(1);
            end
          end
          FUNC_ADVANCE: begin
            if (count != '0) begin
              if (positive) begin
                state_next = ST_SCAN;
              end else begin
                rptr_next   = rptr_inc;
                count_next  = count - CW'(1);
                played_next = played + 32'd1;
                caught_next = 1'b1;
              end
            end
          end
          FUNC_FLUSH: begin
            clear       = 1'b1;
            rptr_next   = '0;
            wptr_next   = '0;
            count_next  = '0;
            played_next = '0;
          end
          default: begin
          end
        endcase
      end

      ST_SCAN: begin
        if (head_less) begin
          rptr_next   = rptr_inc;
          count_next  = count - CW'(1);
          played_next = played + 32'd1;
          if (count == CW'(1)) begin
            // The ring ran dry before reaching the target.
            state_next = ST_DONE;
          end
        end else begin
          caught_next = 1'b1;
          state_next  = ST_DONE;
        end
      end

      ST_NEXT: begin
        state_next = ST_DONE;
      end

      ST_DONE: begin
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Display slot: head plus the offset clipped to the fill count, wrapped once.
  assign off_ext  = {1'b0, req_q.display_offset};
  assign cnt_ext  = 9'(count);
  assign off_clip = (off_ext < cnt_ext) ? off_ext : cnt_ext;
  assign slot_sum = SW'(rptr) + SW'(off_clip);
  assign slot_mod = (slot_sum >= SW'(DEPTH)) ? slot_sum - SW'(DEPTH) : slot_sum;

  assign done = (state == ST_DONE);

  always_comb begin
    result.caught_up       = caught;
    result.frames_buffered = 4'(count);
    result.frames_played   = played;
    result.next_pts        = (count != '0) ? rd_data : 64'sd0;
    result.ready_for_frame = !full;
    result.show_slot       = 3'(slot_mod);
    result.overflow        = ovf;
  end

endmodule
`default_nettype wire

[verif/frame_queue_pts_catchup_tb.sv]
`timescale 1ns / 1ps

module frame_queue_pts_catchup_tb;
  import fqpc_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEFAULT;
  // The one request code that the block has no operation for.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Cycles to let pass after the last expected word, longer than the slowest catch-up.
  localparam int SETTLE_CYCLES = RING_DEPTH + 8;
  localparam int RANDOM_WORDS = 550;

  // Tracks the frame ring as the block should see it and holds the status words it
  // should send back, oldest first.
  class frame_ring_tracker;
    logic signed [63:0] stamp [RING_DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned held;
    logic [31:0] consumed;
    rsp_t awaited[$];
    int unsigned mismatch_count;

    function new();
      clear();
      mismatch_count = 0;
    endfunction

    function void clear();
      foreach (stamp[i]) stamp[i] = '0;
      head = 0;
      tail = 0;
      held = 0;
      consumed = '0;
    endfunction

    function void drop_head();
      held--;
      consumed++;
      head = (head + 1) % RING_DEPTH;
    endfunction

    // Applies one accepted request word and queues the status word it must produce.
    function void note_request(req_t w);
      rsp_t s;
      logic signed [63:0] goal;
      int unsigned shown;
      s = '0;
      goal = {{32{w.target_pts[31]}}, w.target_pts};
      case (w.func)
        FUNC_ADD: begin
          if (held >= RING_DEPTH) begin
            s.overflow = 1'b1;
          end else begin
            if (w.frame_present) stamp[tail] = w.frame_pts;
            tail = (tail + 1) % RING_DEPTH;
            held++;
          end
        end
        FUNC_ADVANCE: begin
          if (held > 0) begin
            if (!w.target_pts[31] && w.target_pts != 0) begin
              // Catch up: drop head frames that are older than the target.
              while (held > 0 && !s.caught_up) begin
                if (stamp[head] < goal) drop_head();
                else s.caught_up = 1'b1;
              end
            end else begin
              drop_head();
              s.caught_up = 1'b1;
            end
          end
        end
        FUNC_FLUSH: clear();
        default: ;
      endcase
      shown = (w.display_offset < held) ? w.display_offset : held;
      s.frames_buffered = 4'(held);
      s.frames_played = consumed;
      s.next_pts = (held > 0) ? stamp[(head + 1) % RING_DEPTH] : '0;
      s.ready_for_frame = (held < RING_DEPTH);
      s.show_slot = 3'((head + shown) % RING_DEPTH);
      awaited.push_back(s);
    endfunction

    // Compares one status word from the block with the oldest one waiting.
    function void check_result(rsp_t got);
      rsp_t want;
      bit bad;
      if (awaited.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("status word with none expected: %p", got);
        return;
      end
      want = awaited.pop_front();
      bad = (got.caught_up !== want.caught_up) ||
            (got.frames_buffered !== want.frames_buffered) ||
            (got.frames_played !== want.frames_played) ||
            (got.next_pts !== want.next_pts) ||
            (got.ready_for_frame !== want.ready_for_frame) ||
            (got.show_slot !== want.show_slot) ||
            (got.overflow !== want.overflow);
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch expected: caught=%0d held=%0d played=%0d next=%0d ready=%0d slot=%0d ovf=%0d",
                   want.caught_up, want.frames_buffered, want.frames_played, want.next_pts,
                   want.ready_for_frame, want.show_slot, want.overflow);
          $display("         actual:   caught=%0d held=%0d played=%0d next=%0d ready=%0d slot=%0d ovf=%0d",
                   got.caught_up, got.frames_buffered, got.frames_played, got.next_pts,
                   got.ready_for_frame, got.show_slot, got.overflow);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t result;

  frame_ring_tracker ring = new();

  // Running timestamp for well-formed streams, kept inside the positive 32-bit range so
  // that catch-up targets can land among the queued frames.
  longint stream_pts;

  frame_queue_pts_catchup dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result)
  );

  always #10 clk = ~clk;

  // The status word is on the port for one cycle only, so it is taken at every edge that
  // ends a done cycle. Values seen here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && done) ring.check_result(result);
  end

  // Presents a word and holds it until an edge with busy low takes it. Start is left high
  // so that a word that follows at once does not lower and raise it in one time step.
  task automatic send_word(input req_t w);
    req <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    ring.note_request(w);
  endtask

  // Sender gap: none when gaps are off; otherwise mostly none, sometimes short, now and then long.
  task automatic idle_sender(input bit allow_gaps);
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (!allow_gaps || pick < 60) len = 0;
    else if (pick < 90) len = $urandom_range(1, 3);
    else if (pick < 97) len = $urandom_range(4, 10);
    else len = $urandom_range(20, 60);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // Holds the sender off until every status word that is owed has arrived.
  task automatic drain_ring();
    start <= 1'b0;
    @(posedge clk);
    while (ring.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic req_t make_word(input logic [1:0] func, input logic present,
                                     input logic [63:0] pts, input logic [31:0] target,
                                     input logic [7:0] offset);
    req_t w;
    w.func = func;
    w.frame_present = present;
    w.frame_pts = pts;
    w.target_pts = target;
    w.display_offset = offset;
    return w;
  endfunction

  // One random word. Most of them follow a rising timestamp stream so that catch-up
  // advances drop a varying number of frames; the rest carry arbitrary values.
  function automatic req_t random_word();
    req_t w;
    int unsigned pick;
    longint goal;
    w = make_word(FUNC_ADD, 1'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom,
                  ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 9)) : 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      w.func = FUNC_ADD;
      w.frame_present = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 99) < 85) begin
        stream_pts += $urandom_range(1, 3000);
        if (stream_pts > 64'd2000000000) stream_pts = $urandom_range(1, 1000);
        w.frame_pts = stream_pts;
      end
    end else if (pick < 95) begin
      w.func = FUNC_ADVANCE;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        goal = stream_pts - longint'($urandom_range(0, 12000));
        if (goal < 1) goal = 1;
        w.target_pts = 32'(goal);
      end else if (pick < 80) begin
        w.target_pts = '0;
      end else if (pick < 90) begin
        w.target_pts = $urandom | 32'h8000_0000;
      end
    end else if (pick < 98) begin
      w.func = FUNC_FLUSH;
    end else begin
      w.func = FUNC_UNUSED;
    end
    return w;
  endfunction

  initial begin
    bit gaps_on;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Advancing an empty ring fails, the unused code only reports.
    send_word(make_word(FUNC_ADVANCE, 1'b0, '0, '0, 8'd0));
    send_word(make_word(FUNC_UNUSED, 1'b1, '1, '1, 8'd3));
    // Fill the ring with the timestamp extremes, a frameless add that keeps the old zero
    // timestamp, and an unordered one.
    send_word(make_word(FUNC_ADD, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, '0, 8'd255));
    send_word(make_word(FUNC_ADD, 1'b1, 64'h8000_0000_0000_0000, '1, 8'd1));
    send_word(make_word(FUNC_ADD, 1'b0, 64'h1234_5678_9ABC_DEF0, '0, 8'd2));
    send_word(make_word(FUNC_ADD, 1'b1, 64'd100, '0, 8'd0));
    send_word(make_word(FUNC_ADD, 1'b1, 64'd200, '0, 8'd7));
    send_word(make_word(FUNC_ADD, 1'b1, 64'd300, '0, 8'd8));
    send_word(make_word(FUNC_ADD, 1'b1, -64'sd5, '0, 8'd9));
    send_word(make_word(FUNC_ADD, 1'b1, 64'd400, '0, 8'd4));
    // The ring is full now, so this add is refused and flagged.
    send_word(make_word(FUNC_ADD, 1'b1, 64'd500, '0, 8'd255));
    send_word(make_word(FUNC_UNUSED, 1'b0, '0, '0, 8'd255));
    // Zero, minus one and the most negative target each step exactly one frame.
    send_word(make_word(FUNC_ADVANCE, 1'b0, '0, 32'd0, 8'd1));
    send_word(make_word(FUNC_ADVANCE, 1'b0, '0, 32'hFFFF_FFFF, 8'd2));
    send_word(make_word(FUNC_ADVANCE, 1'b0, '0, 32'h8000_0000, 8'd3));
    // Catch up past 100 and 200, stop at 300; then a target already reached.
    send_word(make_word(FUNC_ADVANCE, 1'b0, '0, 32'd250, 8'd0));
    send_word(make_word(FUNC_ADVANCE, 1'b0, '0, 32'd1, 8'd5));
    send_word(make_word(FUNC_ADD, 1'b1, 64'd50, '0, 8'd2));
    // The largest target drains the ring and the advance fails.
    send_word(make_word(FUNC_ADVANCE, 1'b0, '0, 32'h7FFF_FFFF, 8'd6));
    send_word(make_word(FUNC_ADVANCE, 1'b1, '0, 32'd77, 8'd0));
    send_word(make_word(FUNC_ADD, 1'b1, 64'h0000_0000_8000_0000, '0, 8'd0));
    send_word(make_word(FUNC_ADVANCE, 1'b0, '0, 32'h7FFF_FFFF, 8'd1));
    send_word(make_word(FUNC_FLUSH, 1'b1, '1, '1, 8'd255));
    send_word(make_word(FUNC_ADVANCE, 1'b0, '0, 32'd0, 8'd0));
    send_word(make_word(FUNC_ADD, 1'b0, '1, '0, 8'd7));

    // Let everything owed come back before the random part starts.
    drain_ring();

    // Random part. Gaps switch on and off in stretches, and the sender waits for the
    // ring to report every owed word now and then.
    stream_pts = $urandom_range(1, 1000);
    gaps_on = 1'b1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      send_word(random_word());
      if (n % 90 == 89) drain_ring();
      else idle_sender(gaps_on);
    end

    drain_ring();
    if (ring.mismatch_count == 0 && ring.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Safety net far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/fqpc_pkg.sv
rtl/core/fqpc_pts_ram.sv
rtl/core/frame_queue_pts_catchup.sv
verif/frame_queue_pts_catchup_tb.sv
